[rtl/core/cpu6502_byte_stream_to_ir_decoder_unit_macros.svh]
// Assertion macros for the 6502 predecoder
`ifndef CPU6502_BYTE_STREAM_TO_IR_DECODER_UNIT_MACROS_SVH
`define CPU6502_BYTE_STREAM_TO_IR_DECODER_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[rtl/core/c6502_pkg.sv]
// Package: types, opcode map, length function and IR flag function for the 6502 predecoder
package c6502_pkg;

  localparam logic [7:0] MAX_NODES = 8'd64;
  localparam logic [7:0] RAW_CODE  = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       start_block;
  } c6502_in_t;

  typedef struct packed {
    logic [7:0]  ir_opcode;
    logic [7:0]  node_flags;
    logic [15:0] node_operand;
    logic        stored;
    logic [7:0]  node_number;
    logic [7:0]  size_estimate;
    logic [7:0]  buffer_node_total;
    logic        last_in_run;
  } c6502_out_t;

  // candidate node before counting
  typedef struct packed {
    logic [7:0]  code;
    logic [7:0]  flags;
    logic [15:0] operand;
    logic [1:0]  size_add;
  } c6502_node_t;

  // up to three nodes from one byte, plus state update
  typedef struct packed {
    logic [1:0]       count;
    c6502_node_t [2:0] nodes;
    logic [7:0]       base_total;
    logic [7:0]       base_size;
    logic [7:0]       base_start;
    logic             last;
  } c6502_run_t;

  function automatic logic [1:0] op_len(input logic [7:0] b);
    logic [1:0] r;
    logic [3:0] lo;
    lo = b[3:0];
    r = 2'd0;
    if (b[4]) begin
      case (lo)
        4'h0, 4'h1, 4'h5, 4'h6: r = 2'd2;
        4'h8: r = 2'd1;
        4'h9, 4'hD: r = 2'd3;
        4'hE: r = (b == 8'h9E) ? 2'd0 : 2'd3;
        4'h4: r = (b == 8'h94 || b == 8'hB4) ? 2'd2 : 2'd0;
        4'hA: r = (b == 8'h9A || b == 8'hBA) ? 2'd1 : 2'd0;
        4'hC: r = (b == 8'hBC) ? 2'd3 : 2'd0;
        default: r = 2'd0;
      endcase
      if (b == 8'h9D) r = 2'd3;
      if (b == 8'h99) r = 2'd3;
      if (b == 8'hBE) r = 2'd3;
      if (b == 8'h9E) r = 2'd0;
      if (b == 8'h9C) r = 2'd0;
    end else begin
      case (lo)
        4'h1, 4'h5, 4'h6: r = 2'd2;
        4'h0: r = (b == 8'h00 || b == 8'h40 || b == 8'h60) ? 2'd1 :
                  (b == 8'h20) ? 2'd3 : (b == 8'h80) ? 2'd0 : 2'd2;
        4'h8: r = 2'd1;
        4'h9: r = (b == 8'h89) ? 2'd0 : 2'd2;
        4'hA: r = 2'd1;
        4'h2: r = (b == 8'hA2) ? 2'd2 : 2'd0;
        4'h4: r = (b == 8'h24 || b[7]) ? 2'd2 : 2'd0;
        4'hC: r = (b == 8'h0C) ? 2'd0 : 2'd3;
        4'hD, 4'hE: r = 2'd3;
        default: r = 2'd0;
      endcase
    end
    return r;
  endfunction

  localparam logic [7:0] OP_MAP [256] = '{
    8'h1F,8'h00,8'h00,8'h00,8'h00,8'h3D,8'h4C,8'h00,8'h13,8'h35,8'h56,8'h00,8'h00,8'h45,8'h52,8'h00,
    8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h18,8'h67,8'h00,8'h00,8'h00,8'h61,8'h6E,8'h00,
    8'h11,8'h00,8'h00,8'h00,8'h72,8'h3C,8'h4E,8'h00,8'h14,8'h34,8'h58,8'h00,8'h73,8'h44,8'h54,8'h00,
    8'h21,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h19,8'h66,8'h00,8'h00,8'h00,8'h60,8'h70,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h3E,8'h4D,8'h00,8'h15,8'h36,8'h57,8'h00,8'h10,8'h46,8'h53,8'h00,
    8'h22,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1C,8'h68,8'h00,8'h00,8'h00,8'h62,8'h6F,8'h00,
    8'h12,8'h00,8'h00,8'h00,8'h00,8'h3A,8'h4F,8'h00,8'h16,8'h32,8'h59,8'h00,8'h00,8'h42,8'h55,8'h00,
    8'h23,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1D,8'h64,8'h00,8'h00,8'h00,8'h5E,8'h71,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h0E,8'h0A,8'h0C,8'h00,8'h31,8'h00,8'h2A,8'h00,8'h0F,8'h0B,8'h0D,8'h00,
    8'h24,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2B,8'h5D,8'h2D,8'h00,8'h00,8'h5C,8'h00,8'h00,
    8'h07,8'h00,8'h04,8'h00,8'h08,8'h02,8'h05,8'h00,8'h29,8'h01,8'h28,8'h00,8'h09,8'h03,8'h06,8'h00,
    8'h25,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1E,8'h5B,8'h2C,8'h00,8'h6B,8'h5A,8'h6A,8'h00,
    8'h39,8'h00,8'h00,8'h00,8'h41,8'h3F,8'h4B,8'h00,8'h2F,8'h37,8'h30,8'h00,8'h49,8'h47,8'h51,8'h00,
    8'h26,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1A,8'h69,8'h00,8'h00,8'h00,8'h63,8'h6D,8'h00,
    8'h38,8'h00,8'h00,8'h00,8'h40,8'h3B,8'h4A,8'h00,8'h2E,8'h33,8'h17,8'h00,8'h48,8'h43,8'h50,8'h00,
    8'h27,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1B,8'h65,8'h00,8'h00,8'h00,8'h5F,8'h6C,8'h00
  };

  localparam logic [7:0] RD_A = 8'h01, RD_X = 8'h02, RD_Y = 8'h04, RD_P = 8'h08;
  localparam logic [7:0] WR_A = 8'h10, WR_X = 8'h20, WR_Y = 8'h40, WR_P = 8'h80;

  function automatic logic [7:0] flags_for(input logic [7:0] ir);
    logic [7:0] f;
    case (ir) inside
      8'h01, 8'h02, 8'h03, 8'h5A, 8'h5B, 8'h16: f = WR_A | WR_P;
      8'h04, 8'h05, 8'h06, 8'h6A, 8'h2C: f = WR_X | WR_P;
      8'h07, 8'h08, 8'h09, 8'h6B: f = WR_Y | WR_P;
      8'h0A, 8'h0B, 8'h5C, 8'h5D, 8'h15: f = RD_A;
      8'h0C, 8'h0D, 8'h2D: f = RD_X;
      8'h0E, 8'h0F: f = RD_Y;
      8'h32, 8'h33, 8'h42, 8'h43, 8'h5E, 8'h5F, 8'h64, 8'h65:
        f = RD_A | RD_P | WR_A | WR_P;
      8'h34, 8'h35, 8'h36, 8'h44, 8'h45, 8'h46, 8'h60, 8'h61, 8'h62,
      8'h66, 8'h67, 8'h68, [8'h56:8'h59]: f = RD_A | WR_A | WR_P;
      8'h37, 8'h47, 8'h63, 8'h69, 8'h73: f = RD_A | WR_P;
      8'h38, 8'h48: f = RD_X | WR_P;
      8'h39, 8'h49: f = RD_Y | WR_P;
      [8'h4A:8'h55], [8'h6C:8'h71], [8'h18:8'h1E], 8'h14: f = WR_P;
      [8'h20:8'h27], 8'h13: f = RD_P;
      8'h28: f = RD_A | WR_X | WR_P;
      8'h29: f = RD_A | WR_Y | WR_P;
      8'h2A: f = RD_X | WR_A | WR_P;
      8'h2B: f = RD_Y | WR_A | WR_P;
      8'h2E, 8'h30: f = RD_X | WR_X | WR_P;
      8'h2F, 8'h31: f = RD_Y | WR_Y | WR_P;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

[rtl/core/c6502_decode.sv]
// Byte gathering and node formation for one input transaction
module c6502_decode import c6502_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  c6502_in_t  in_item,
  output c6502_run_t run
);

  logic [7:0] held_opcode_r, held_opcode_nxt;
  logic [7:0] held_low_r, held_low_nxt;
  logic [1:0] held_r, held_nxt;
  logic [7:0] total_r, total_nxt;
  logic [7:0] size_r, size_nxt;
  logic [7:0] start_r, start_nxt;

  function automatic c6502_node_t raw_node(input logic [7:0] b);
    c6502_node_t n;
    n.code = RAW_CODE;
    n.flags = 8'h00;
    n.operand = {8'h00, b};
    n.size_add = 2'd0;
    return n;
  endfunction

  function automatic c6502_node_t map_node(input logic [7:0] ir, input logic [15:0] opnd,
                                           input logic [1:0] len);
    c6502_node_t n;
    n.code = ir;
    n.flags = flags_for(ir);
    n.operand = opnd;
    n.size_add = len;
    return n;
  endfunction

  logic [7:0] b;
  logic [1:0] blen, hlen;
  logic [7:0] bmap, hmap;
  logic [7:0] bt, bs, bst;
  // per-node stored decision, counters advance through the run
  logic [7:0] t1, s1;
  logic [1:0] cnt;
  c6502_node_t [2:0] nd;

  assign b = in_item.data_byte;
  assign blen = op_len(b);
  assign hlen = op_len(held_opcode_r);
  assign bmap = OP_MAP[b];
  assign hmap = OP_MAP[held_opcode_r];

  always_comb begin
    bt = in_item.start_block ? 8'h00 : total_r;
    bs = in_item.start_block ? 8'h00 : size_r;
    bst = in_item.start_block ? 8'h00 : start_r;
    held_opcode_nxt = held_opcode_r;
    held_low_nxt = held_low_r;
    held_nxt = 2'd0;
    cnt = 2'd0;
    nd = '0;
    if (held_r == 2'd1 && hlen != 2'd3) begin
      if (hmap != 8'h00) begin
        cnt = 2'd1; nd[0] = map_node(hmap, {8'h00, b}, 2'd2);
      end else begin
        cnt = 2'd2; nd[0] = raw_node(held_opcode_r); nd[1] = raw_node(b);
      end
    end else if (held_r == 2'd1 && in_item.last_byte) begin
      nd[0] = raw_node(held_opcode_r);
      cnt = 2'd2;
      if (blen == 2'd1 && bmap != 8'h00) nd[1] = map_node(bmap, 16'h0000, 2'd1);
      else nd[1] = raw_node(b);
    end else if (held_r == 2'd1) begin
      held_low_nxt = b;
      held_nxt = 2'd2;
    end else if (held_r == 2'd2) begin
      if (hmap != 8'h00) begin
        cnt = 2'd1; nd[0] = map_node(hmap, {b, held_low_r}, 2'd3);
      end else begin
        cnt = 2'd3; nd[0] = raw_node(held_opcode_r);
        nd[1] = raw_node(held_low_r); nd[2] = raw_node(b);
      end
    end else begin
      if (blen == 2'd0 || (blen != 2'd1 && in_item.last_byte)) begin
        cnt = 2'd1; nd[0] = raw_node(b);
      end else if (blen == 2'd1) begin
        cnt = 2'd1;
        nd[0] = (bmap != 8'h00) ? map_node(bmap, 16'h0000, 2'd1) : raw_node(b);
      end else begin
        held_opcode_nxt = b;
        held_nxt = 2'd1;
      end
    end
    if (in_item.last_byte) held_nxt = 2'd0;
    // counter after the whole run: stored nodes up to capacity
    t1 = bt; s1 = bs;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < cnt && t1 < MAX_NODES) begin
        t1 = t1 + 8'd1;
        s1 = s1 + {6'd0, nd[i].size_add};
      end
    end
    total_nxt = t1;
    size_nxt = s1;
    start_nxt = in_item.last_byte ? t1 : bst;
  end

  assign run.count = cnt;
  assign run.nodes = nd;
  assign run.base_total = bt;
  assign run.base_size = bs;
  assign run.base_start = bst;
  assign run.last = in_item.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_opcode_r <= 8'h00;
      held_low_r <= 8'h00;
      held_r <= 2'd0;
      total_r <= 8'h00;
      size_r <= 8'h00;
      start_r <= 8'h00;
    end else if (step) begin
      held_opcode_r <= held_opcode_nxt;
      held_low_r <= held_low_nxt;
      held_r <= held_nxt;
      total_r <= total_nxt;
      size_r <= size_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

[rtl/core/c6502_emit.sv]
// Result queue: holds one run of up to three nodes and hands them out in order
module c6502_emit import c6502_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  c6502_run_t run,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_ready,
  output c6502_out_t out_data
);
  `include "cpu6502_byte_stream_to_ir_decoder_unit_macros.svh"

  c6502_out_t [2:0] q_r, q_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] rd_r, rd_nxt;

  logic [7:0] t, s;
  always_comb begin
    q_nxt = q_r;
    t = run.base_total;
    s = run.base_size;
    for (int i = 0; i < 3; i++) begin
      q_nxt[i].ir_opcode = run.nodes[i].code;
      q_nxt[i].node_flags = run.nodes[i].flags;
      q_nxt[i].node_operand = run.nodes[i].operand;
      q_nxt[i].node_number = t;
      q_nxt[i].stored = (t < MAX_NODES);
      if (t < MAX_NODES) begin
        t = t + 8'd1;
        s = s + {6'd0, run.nodes[i].size_add};
      end
      q_nxt[i].size_estimate = s;
      q_nxt[i].buffer_node_total = t - run.base_start;
      q_nxt[i].last_in_run = (2'(i + 1) == run.count);
    end
  end

  logic pop;
  assign out_valid = (cnt_r != 2'd0);
  assign pop = out_valid && out_ready;
  // final node leaving frees the queue in the same cycle
  assign busy = out_valid && !(pop && (rd_r + 2'd1 == cnt_r));
  assign out_data = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    rd_nxt = rd_r;
    if (pop) begin
      if (rd_r + 2'd1 == cnt_r) begin
        cnt_nxt = 2'd0; rd_nxt = 2'd0;
      end else rd_nxt = rd_r + 2'd1;
    end
    if (load) begin
      cnt_nxt = run.count; rd_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
    end
    if (load) q_r <= q_nxt;
  end

  `CHK_IMPL(a_rd_in_range, out_valid, rd_r < cnt_r)
  `CHK_IMPL(a_no_load_busy, load && run.count != 2'd0, !busy)
  `CHK_IMPL(a_last_flag, out_valid, out_data.last_in_run == (rd_r + 2'd1 == cnt_r))
  `CHK_NEXT(a_hold, out_valid && !out_ready && !load, out_valid && $stable(rd_r))

endmodule

[rtl/core/cpu6502_byte_stream_to_ir_decoder_unit.sv]
// 6502 machine-code predecoder: byte stream in, IR nodes out
// The first node of a byte transaction appears on the output in the cycle after it is accepted.
// Accepts one byte per cycle while out_ready is high; a byte making two or
// three nodes keeps in_ready low until its final node leaves the queue.
// Reset (rst_n low, synchronous) clears held bytes, counters and the queue.
module cpu6502_byte_stream_to_ir_decoder_unit import c6502_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  c6502_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output c6502_out_t out_data
);

  c6502_run_t run;
  logic busy, step;

  assign in_ready = !busy;
  assign step = in_valid && in_ready;

  c6502_decode u_dec (
    .clk(clk), .rst_n(rst_n), .step(step), .in_item(in_data), .run(run)
  );

  c6502_emit u_emit (
    .clk(clk), .rst_n(rst_n), .load(step), .run(run), .busy(busy),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

[verif/cpu6502_byte_stream_to_ir_decoder_unit_checker.sv]
// Checker for the 6502 predecoder: predicts IR nodes per byte and compares them
module cpu6502_byte_stream_to_ir_decoder_unit_checker import c6502_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  c6502_in_t  in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  c6502_out_t out_data,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] NODE_LIMIT = 8'd64;

  localparam logic [7:0] F_RA = 8'h01, F_RX = 8'h02, F_RY = 8'h04, F_RP = 8'h08;
  localparam logic [7:0] F_WA = 8'h10, F_WX = 8'h20, F_WY = 8'h40, F_WP = 8'h80;

  localparam int INSN_LEN [256] = '{
    1,2,0,0,0,2,2,0,1,2,1,0,0,3,3,0,
    2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0,
    3,2,0,0,2,2,2,0,1,2,1,0,3,3,3,0,
    2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0,
    1,2,0,0,0,2,2,0,1,2,1,0,3,3,3,0,
    2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0,
    1,2,0,0,0,2,2,0,1,2,1,0,3,3,3,0,
    2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0,
    0,2,0,0,2,2,2,0,1,0,1,0,3,3,3,0,
    2,2,0,0,2,2,2,0,1,3,1,0,0,3,0,0,
    2,2,2,0,2,2,2,0,1,2,1,0,3,3,3,0,
    2,2,0,0,2,2,2,0,1,3,1,0,3,3,3,0,
    2,2,0,0,2,2,2,0,1,2,1,0,3,3,3,0,
    2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0,
    2,2,0,0,2,2,2,0,1,2,1,0,3,3,3,0,
    2,2,0,0,0,2,2,0,1,3,0,0,0,3,3,0
  };

  localparam logic [7:0] IR_OF [256] = '{
    8'h1F,8'h00,8'h00,8'h00,8'h00,8'h3D,8'h4C,8'h00,8'h13,8'h35,8'h56,8'h00,8'h00,8'h45,8'h52,8'h00,
    8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h18,8'h67,8'h00,8'h00,8'h00,8'h61,8'h6E,8'h00,
    8'h11,8'h00,8'h00,8'h00,8'h72,8'h3C,8'h4E,8'h00,8'h14,8'h34,8'h58,8'h00,8'h73,8'h44,8'h54,8'h00,
    8'h21,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h19,8'h66,8'h00,8'h00,8'h00,8'h60,8'h70,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h3E,8'h4D,8'h00,8'h15,8'h36,8'h57,8'h00,8'h10,8'h46,8'h53,8'h00,
    8'h22,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1C,8'h68,8'h00,8'h00,8'h00,8'h62,8'h6F,8'h00,
    8'h12,8'h00,8'h00,8'h00,8'h00,8'h3A,8'h4F,8'h00,8'h16,8'h32,8'h59,8'h00,8'h00,8'h42,8'h55,8'h00,
    8'h23,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1D,8'h64,8'h00,8'h00,8'h00,8'h5E,8'h71,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h0E,8'h0A,8'h0C,8'h00,8'h31,8'h00,8'h2A,8'h00,8'h0F,8'h0B,8'h0D,8'h00,
    8'h24,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2B,8'h5D,8'h2D,8'h00,8'h00,8'h5C,8'h00,8'h00,
    8'h07,8'h00,8'h04,8'h00,8'h08,8'h02,8'h05,8'h00,8'h29,8'h01,8'h28,8'h00,8'h09,8'h03,8'h06,8'h00,
    8'h25,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1E,8'h5B,8'h2C,8'h00,8'h6B,8'h5A,8'h6A,8'h00,
    8'h39,8'h00,8'h00,8'h00,8'h41,8'h3F,8'h4B,8'h00,8'h2F,8'h37,8'h30,8'h00,8'h49,8'h47,8'h51,8'h00,
    8'h26,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1A,8'h69,8'h00,8'h00,8'h00,8'h63,8'h6D,8'h00,
    8'h38,8'h00,8'h00,8'h00,8'h40,8'h3B,8'h4A,8'h00,8'h2E,8'h33,8'h17,8'h00,8'h48,8'h43,8'h50,8'h00,
    8'h27,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h1B,8'h65,8'h00,8'h00,8'h00,8'h5F,8'h6C,8'h00
  };

  // predictor state
  logic [7:0] hold_op, hold_lo, nodes_in_block, native_size, buf_base;
  logic [1:0] held_cnt;
  int         run_nodes;
  c6502_out_t node_q [$];

  assign pending = node_q.size();

  function automatic logic [7:0] reg_use(input logic [7:0] ir);
    case (ir)
      8'h01, 8'h02, 8'h03, 8'h5A, 8'h5B, 8'h16: return F_WA | F_WP;
      8'h04, 8'h05, 8'h06, 8'h6A, 8'h2C: return F_WX | F_WP;
      8'h07, 8'h08, 8'h09, 8'h6B: return F_WY | F_WP;
      8'h0A, 8'h0B, 8'h5C, 8'h5D, 8'h15: return F_RA;
      8'h0C, 8'h0D, 8'h2D: return F_RX;
      8'h0E, 8'h0F: return F_RY;
      8'h32, 8'h33, 8'h42, 8'h43, 8'h5E, 8'h5F, 8'h64, 8'h65:
        return F_RA | F_RP | F_WA | F_WP;
      8'h34, 8'h35, 8'h36, 8'h44, 8'h45, 8'h46, 8'h60, 8'h61, 8'h62,
      8'h66, 8'h67, 8'h68, 8'h56, 8'h57, 8'h58, 8'h59: return F_RA | F_WA | F_WP;
      8'h37, 8'h47, 8'h63, 8'h69, 8'h73: return F_RA | F_WP;
      8'h38, 8'h48: return F_RX | F_WP;
      8'h39, 8'h49: return F_RY | F_WP;
      8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53,
      8'h54, 8'h55, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h18, 8'h19,
      8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h14: return F_WP;
      8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h13: return F_RP;
      8'h28: return F_RA | F_WX | F_WP;
      8'h29: return F_RA | F_WY | F_WP;
      8'h2A: return F_RX | F_WA | F_WP;
      8'h2B: return F_RY | F_WA | F_WP;
      8'h2E, 8'h30: return F_RX | F_WX | F_WP;
      8'h2F, 8'h31: return F_RY | F_WY | F_WP;
      default: return 8'h00;
    endcase
  endfunction

  task automatic emit_node(input logic [7:0] code, input logic [7:0] flags,
                           input logic [15:0] operand, input logic [7:0] size_add);
    c6502_out_t n;
    if (run_nodes >= 3) return;
    n = '0;
    n.ir_opcode    = code;
    n.node_flags   = flags;
    n.node_operand = operand;
    n.node_number  = nodes_in_block;
    if (nodes_in_block < NODE_LIMIT) begin
      n.stored = 1'b1;
      nodes_in_block = nodes_in_block + 8'd1;
      native_size    = native_size + size_add;
    end
    n.size_estimate     = native_size;
    n.buffer_node_total = nodes_in_block - buf_base;
    node_q.push_back(n);
    run_nodes++;
  endtask

  task automatic emit_raw(input logic [7:0] b);
    emit_node(RAW_CODE, 8'h00, {8'h00, b}, 8'd0);
  endtask

  task automatic close_insn(input logic [7:0] opc, input logic [7:0] lo,
                            input logic [7:0] hi, input int len);
    logic [7:0] ir;
    ir = IR_OF[opc];
    held_cnt = 2'd0;
    if (ir != 8'h00) begin
      emit_node(ir, reg_use(ir), (len == 3) ? {hi, lo} : {8'h00, lo}, 8'(len));
    end else begin
      emit_raw(opc);
      emit_raw(lo);
      if (len == 3) emit_raw(hi);
    end
  endtask

  task automatic open_insn(input logic [7:0] b, input logic last);
    int len;
    len = INSN_LEN[b];
    if (len == 0 || (len > 1 && last)) begin
      emit_raw(b);
    end else if (len == 1) begin
      if (IR_OF[b] != 8'h00) emit_node(IR_OF[b], reg_use(IR_OF[b]), 16'h0000, 8'd1);
      else emit_raw(b);
    end else begin
      hold_op  = b;
      held_cnt = 2'd1;
    end
  endtask

  task automatic predict_byte(input c6502_in_t t);
    run_nodes = 0;
    if (t.start_block) begin
      nodes_in_block = '0;
      native_size    = '0;
      buf_base       = '0;
    end
    if (held_cnt == 2'd1) begin
      if (INSN_LEN[hold_op] != 3) begin
        close_insn(hold_op, t.data_byte, 8'h00, 2);
      end else if (t.last_byte) begin
        // cut short: opcode goes raw, this byte is decoded afresh
        held_cnt = 2'd0;
        emit_raw(hold_op);
        open_insn(t.data_byte, 1'b1);
      end else begin
        hold_lo  = t.data_byte;
        held_cnt = 2'd2;
      end
    end else if (held_cnt == 2'd2) begin
      close_insn(hold_op, hold_lo, t.data_byte, 3);
    end else begin
      held_cnt = 2'd0;
      open_insn(t.data_byte, t.last_byte);
    end
    if (t.last_byte) begin
      held_cnt = 2'd0;
      buf_base = nodes_in_block;
    end
    if (run_nodes > 0) node_q[node_q.size() - 1].last_in_run = 1'b1;
  endtask

  task automatic report(input string field, input int got, input int want);
    $display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    hold_op = '0; hold_lo = '0; held_cnt = '0;
    nodes_in_block = '0; native_size = '0; buf_base = '0;
  end

  always @(posedge clk) begin
    c6502_out_t w;
    if (rst_n) begin
      if (in_valid && in_ready) predict_byte(in_data);
      if (out_valid && out_ready) begin
        if (node_q.size() == 0) begin
          report("unexpected node, opcode", out_data.ir_opcode, 0);
        end else begin
          w = node_q.pop_front();
          if (out_data.ir_opcode != w.ir_opcode)
            report("ir_opcode", out_data.ir_opcode, w.ir_opcode);
          if (out_data.node_flags != w.node_flags)
            report("node_flags", out_data.node_flags, w.node_flags);
          if (out_data.node_operand != w.node_operand)
            report("node_operand", out_data.node_operand, w.node_operand);
          if (out_data.stored != w.stored)
            report("stored", out_data.stored, w.stored);
          if (out_data.node_number != w.node_number)
            report("node_number", out_data.node_number, w.node_number);
          if (out_data.size_estimate != w.size_estimate)
            report("size_estimate", out_data.size_estimate, w.size_estimate);
          if (out_data.buffer_node_total != w.buffer_node_total)
            report("buffer_node_total", out_data.buffer_node_total, w.buffer_node_total);
          if (out_data.last_in_run != w.last_in_run)
            report("last_in_run", out_data.last_in_run, w.last_in_run);
        end
      end
    end
  end

endmodule

[verif/cpu6502_byte_stream_to_ir_decoder_unit_tb.sv]
// Testbench top for the 6502 predecoder: byte stimulus, back-pressure and verdict
module cpu6502_byte_stream_to_ir_decoder_unit_tb;
  import c6502_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  c6502_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  c6502_out_t out_data;
  int         fail_count, pending;
  int         cycles = 0;
  bit         calm = 1'b0;
  int         bytes_sent = 0;

  always #5 clk = ~clk;

  cpu6502_byte_stream_to_ir_decoder_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  cpu6502_byte_stream_to_ir_decoder_unit_checker i_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stall before each node
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic start);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: last, start_block: start};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // one instruction with random operands; last_byte now and then
  task automatic send_insn();
    logic [7:0] opc;
    int len;
    opc = 8'($urandom);
    len = i_chk.INSN_LEN[opc];
    if ($urandom_range(0, 9) != 0) begin
      while (i_chk.INSN_LEN[opc] == 0) opc = 8'($urandom);
      len = i_chk.INSN_LEN[opc];
    end else begin
      len = 1;
    end
    send_byte(opc, ($urandom_range(0, 11) == 0), ($urandom_range(0, 39) == 0));
    for (int k = 1; k < len; k++)
      send_byte(8'($urandom), ($urandom_range(0, 7) == 0), ($urandom_range(0, 59) == 0));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: immediates, absolute, implied, unknown, unmapped zero page
    send_byte(8'hA9, 0, 1); send_byte(8'h00, 0, 0);
    send_byte(8'hAD, 0, 0); send_byte(8'hFF, 0, 0); send_byte(8'hFF, 0, 0);
    send_byte(8'hEA, 0, 0); send_byte(8'h00, 0, 0); send_byte(8'h02, 0, 0);
    send_byte(8'hB4, 0, 0); send_byte(8'h5A, 0, 0);
    send_byte(8'hA5, 0, 0); send_byte(8'h80, 0, 0);
    // cut short: three-byte opcode then a multi-byte opcode as last byte
    send_byte(8'h20, 0, 0); send_byte(8'h4C, 1, 0);
    // two-byte opcode as last byte goes raw
    send_byte(8'hA9, 1, 0);
    // block start while holding
    send_byte(8'h8D, 0, 0); send_byte(8'h34, 0, 1); send_byte(8'h12, 1, 0);
    // unknown opcode goes raw, then a complete three-byte one ending the buffer
    send_byte(8'h9E, 0, 0); send_byte(8'hBC, 0, 0); send_byte(8'h01, 0, 0);
    send_byte(8'h02, 1, 0); send_byte(8'h60, 1, 0);

    // hold off until drained
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    while (bytes_sent < 110) begin
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom), $urandom_range(0, 1),
                                               ($urandom_range(0, 19) == 0));
      else send_insn();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/c6502_pkg.sv
rtl/core/c6502_decode.sv
rtl/core/c6502_emit.sv
rtl/core/cpu6502_byte_stream_to_ir_decoder_unit.sv
verif/cpu6502_byte_stream_to_ir_decoder_unit_checker.sv
verif/cpu6502_byte_stream_to_ir_decoder_unit_tb.sv
